/* design/assert_macros.svh */
// Assertion macros included by the top-level parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/ebp_pkg.sv */
// Types and constants shared by the EDID base block parser.
package ebp_pkg;

   localparam logic [47:0] REJECTED_NAME_RESET = 48'h445032564741;

   localparam logic [6:0] POS_HEADER_LAST = 7'h07;
   localparam logic [6:0] POS_STD_FIRST   = 7'h26;
   localparam logic [6:0] POS_DESC_FIRST  = 7'h36;
   localparam logic [6:0] POS_DESC_STOP   = 7'h7E;
   localparam logic [6:0] POS_LAST        = 7'h7F;
   localparam logic [4:0] DESC_LAST       = 5'd17;

   localparam logic [7:0] TAG_MODEL_NAME  = 8'hFC;
   localparam logic [7:0] NAME_PAD        = 8'h0A;
   localparam logic [7:0] HEADER_FILL     = 8'hFF;
   localparam logic [7:0] STD_BLANK       = 8'h01;
   localparam logic [8:0] STD_WIDTH_BIAS  = 9'd31;
   localparam logic [6:0] REFRESH_BIAS    = 7'd60;
   localparam logic [11:0] RECIP_FIVE     = 12'd3277;

   typedef enum logic [1:0] {
      KIND_DETAILED = 2'd0,
      KIND_STANDARD = 2'd1,
      KIND_STATUS   = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      ASPECT_16_10 = 2'd0,
      ASPECT_4_3   = 2'd1,
      ASPECT_5_4   = 2'd2,
      ASPECT_16_9  = 2'd3
   } aspect_type;

   // first 17 bytes of the current descriptor; entry 0 doubles as the std timing byte
   typedef logic [16:0][7:0] held_type;

   typedef struct packed {
      logic       std_second;
      logic       desc_end;
      logic       status;
      logic [2:0] status_flags;
   } view_type;

   typedef struct packed {
      logic            valid;
      result_kind_type kind;
      logic [15:0]     pixel_clock;
      logic [6:0]      refresh_rate;
      logic [11:0]     h_active;
      logic [12:0]     h_sync_start;
      logic [12:0]     h_sync_end;
      logic [12:0]     h_total;
      logic [11:0]     v_active;
      logic [12:0]     v_sync_start;
      logic [12:0]     v_sync_end;
      logic [12:0]     v_total;
      logic [2:0]      flags;
   } result_type;

endpackage

/* design/ebp_tracker.sv */
// Block state: position, byte sum, header and name flags, rejected name, descriptor byte buffer.
module ebp_tracker
   import ebp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [47:0] csr_write_data,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        block_start,
   output view_type    view,
   output held_type    held
);

   logic [47:0] rejected_name_ff;
   logic [6:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic        header_good_ff, header_good_in;
   logic        name_rejected_ff, name_rejected_in;
   logic [4:0]  desc_ff, desc_in;
   held_type    held_ff;

   logic [6:0]  pos;
   logic        restart;
   logic        in_header;
   logic        header_ok;
   logic        in_std;
   logic        in_desc;
   logic [4:0]  desc_idx;
   logic        desc_end;
   logic        name_match;
   logic [55:0] name_ext;

   assign name_ext = {rejected_name_ff, 8'h00};

   // C-string compare of descriptor bytes 5.. against the rejected name
   always_comb begin
      logic [7:0] ch;
      logic [7:0] ref_ch;
      logic       done;
      done       = 1'b0;
      name_match = 1'b0;
      for (int k = 0; k < 7; k++) begin
         ch     = held_ff[5 + k];
         ref_ch = name_ext[55 - 8 * k -: 8];
         if (ch == NAME_PAD) begin
            ch = 8'h00;
         end
         if (!done) begin
            if (ch != ref_ch) begin
               done       = 1'b1;
               name_match = 1'b0;
            end else if (ch == 8'h00) begin
               done       = 1'b1;
               name_match = 1'b1;
            end
         end
      end
   end

   always_comb begin
      pos       = block_start ? 7'd0 : pos_ff;
      restart   = (pos == 7'd0);
      pos_in    = pos + 7'd1;
      sum_in    = (restart ? 8'd0 : sum_ff) + data_byte;

      in_header = (pos <= POS_HEADER_LAST);
      header_ok = (data_byte == HEADER_FILL) ||
                  (((pos == 7'd0) || (pos == POS_HEADER_LAST)) && (data_byte == 8'h00));
      header_good_in = (restart || header_good_ff) && (!in_header || header_ok);

      in_std   = (pos >= POS_STD_FIRST) && (pos < POS_DESC_FIRST);
      in_desc  = (pos >= POS_DESC_FIRST) && (pos < POS_DESC_STOP);
      desc_idx = (pos == POS_DESC_FIRST) ? 5'd0 : desc_ff;
      desc_end = in_desc && (desc_idx == DESC_LAST);

      if (in_desc) begin
         desc_in = desc_end ? 5'd0 : desc_idx + 5'd1;
      end else begin
         desc_in = desc_ff;
      end

      if (desc_end && (held_ff[0] == 8'h00) && (held_ff[3] == TAG_MODEL_NAME)) begin
         name_rejected_in = name_match;
      end else begin
         name_rejected_in = restart ? 1'b0 : name_rejected_ff;
      end

      view.std_second   = in_std && pos[0];
      view.desc_end     = desc_end;
      view.status       = (pos == POS_LAST);
      view.status_flags = {name_rejected_in, !header_good_in, (sum_in != 8'd0)};
   end

   assign held = held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rejected_name_ff <= REJECTED_NAME_RESET;
      end else if (csr_write_enable) begin
         rejected_name_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         sum_ff           <= '0;
         header_good_ff   <= 1'b1;
         name_rejected_ff <= 1'b0;
         desc_ff          <= '0;
      end else if (step) begin
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         header_good_ff   <= header_good_in;
         name_rejected_ff <= name_rejected_in;
         desc_ff          <= desc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         if (in_std && !pos[0]) begin
            held_ff[0] <= data_byte;
         end else if (in_desc && !desc_end) begin
            held_ff[desc_idx] <= data_byte;
         end
      end
   end

endmodule

/* design/ebp_decode.sv */
// Field decode of standard timings, detailed timings and the block status.
module ebp_decode
   import ebp_pkg::*;
(
   input  view_type   view,
   input  held_type   held,
   input  logic [7:0] data_byte,
   output result_type result
);

   logic [8:0]  std_m;
   logic [11:0] std_h;
   logic [20:0] recip_prod;
   logic [11:0] std_v;
   logic        std_blank;
   logic        det_ok;
   logic [11:0] ha, hb, va, vb;
   logic [9:0]  hso, hsw;
   logic [5:0]  vso, vsw;
   logic [12:0] hss, vss;

   always_comb begin
      // width is 8 * m; 16:10 and 4:3 heights are exact multiples of m,
      // 16:9 is 9m/2 and 5:4 goes through a reciprocal of five
      std_m      = {1'b0, held[0]} + STD_WIDTH_BIAS;
      std_h      = {std_m, 3'b000};
      recip_prod = 21'(std_m) * 21'(RECIP_FIVE);
      case (aspect_type'(data_byte[7:6]))
         ASPECT_16_10: std_v = 12'(std_m) * 12'd5;
         ASPECT_4_3:   std_v = 12'(std_m) * 12'd6;
         ASPECT_5_4:   std_v = recip_prod[20:9];
         default:      std_v = 12'((13'(std_m) * 13'd9) >> 1);
      endcase
      std_blank = (held[0] == STD_BLANK) && (data_byte == STD_BLANK);

      ha  = {held[4][7:4], held[2]};
      hb  = {held[4][3:0], held[3]};
      va  = {held[7][7:4], held[5]};
      vb  = {held[7][3:0], held[6]};
      hso = {held[11][7:6], held[8]};
      hsw = {held[11][5:4], held[9]};
      vso = {held[11][3:2], held[10][7:4]};
      vsw = {held[11][1:0], held[10][3:0]};
      hss = 13'(ha) + 13'(hso);
      vss = 13'(va) + 13'(vso);
      det_ok = (held[0] != 8'h00) && (held[1] != 8'h00) &&
               (data_byte[7] || (data_byte[4:3] == 2'b11));

      result = '0;
      result.kind = KIND_DETAILED;
      if (view.std_second && !std_blank) begin
         result.valid        = 1'b1;
         result.kind         = KIND_STANDARD;
         result.refresh_rate = {1'b0, data_byte[5:0]} + REFRESH_BIAS;
         result.h_active     = std_h;
         result.v_active     = std_v;
      end else if (view.desc_end && det_ok) begin
         result.valid        = 1'b1;
         result.kind         = KIND_DETAILED;
         result.pixel_clock  = {held[1], held[0]};
         result.h_active     = ha;
         result.h_sync_start = hss;
         result.h_sync_end   = hss + 13'(hsw);
         result.h_total      = 13'(ha) + 13'(hb);
         result.v_active     = va;
         result.v_sync_start = vss;
         result.v_sync_end   = vss + 13'(vsw);
         result.v_total      = 13'(va) + 13'(vb);
         result.flags        = {data_byte[7],
                                data_byte[4] && data_byte[2],
                                data_byte[4] && data_byte[1]};
      end else if (view.status) begin
         result.valid = 1'b1;
         result.kind  = KIND_STATUS;
         result.flags = view.status_flags;
      end
   end

endmodule

/* design/edid_base_block_parser.sv */
// EDID base block parser: top level with input and result registers.
//
// Usage:
//   req_ channel: one EDID base block byte per word on req_data_byte;
//   req_block_start marks byte 0 and restarts position, sum and flags.
//   Without it the position wraps after byte 127 to a new block.
//   rsp_ channel: at most one result word per byte: a standard timing
//   (kind 1), a detailed timing (kind 0) or the block status at byte 127
//   (kind 2). Fields unused by a kind are zero.
//   csr_ port: csr_write_enable loads the 48-bit rejected model name.
// Timing:
//   One byte per cycle sustained while rsp_stall does not hold the pipe. The byte
//   is registered in the input register and the decode result is then loaded
//   into the result register, which drives rsp_.
// Reset:
//   Synchronous; clears position, sum, flags and both valid bits, and
//   loads the default rejected name.
// Stall:
//   While a result waits under rsp_stall the whole pipe holds and
//   req_stall is raised; no word is lost or repeated.
module edid_base_block_parser
   import ebp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [47:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_block_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_pixel_clock,
   output logic [6:0]  rsp_refresh_rate,
   output logic [11:0] rsp_h_active,
   output logic [12:0] rsp_h_sync_start,
   output logic [12:0] rsp_h_sync_end,
   output logic [12:0] rsp_h_total,
   output logic [11:0] rsp_v_active,
   output logic [12:0] rsp_v_sync_start,
   output logic [12:0] rsp_v_sync_end,
   output logic [12:0] rsp_v_total,
   output logic [2:0]  rsp_flags
);

   `include "assert_macros.svh"

   logic       advance;
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_start_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   view_type   view;
   held_type   held;

   // pipe moves unless a result word sits stalled at the output
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   ebp_tracker u_tracker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (advance && s1_valid_ff),
      .data_byte        (s1_byte_ff),
      .block_start      (s1_start_ff),
      .view             (view),
      .held             (held)
   );

   ebp_decode u_decode (
      .view      (view),
      .held      (held),
      .data_byte (s1_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         rsp_valid_ff <= s1_valid_ff && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_byte_ff  <= req_data_byte;
         s1_start_ff <= req_block_start;
         rsp_ff      <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_ff.kind;
   assign rsp_pixel_clock  = rsp_ff.pixel_clock;
   assign rsp_refresh_rate = rsp_ff.refresh_rate;
   assign rsp_h_active     = rsp_ff.h_active;
   assign rsp_h_sync_start = rsp_ff.h_sync_start;
   assign rsp_h_sync_end   = rsp_ff.h_sync_end;
   assign rsp_h_total      = rsp_ff.h_total;
   assign rsp_v_active     = rsp_ff.v_active;
   assign rsp_v_sync_start = rsp_ff.v_sync_start;
   assign rsp_v_sync_end   = rsp_ff.v_sync_end;
   assign rsp_v_total      = rsp_ff.v_total;
   assign rsp_flags        = rsp_ff.flags;

   `ASSERT_IMPLIES(a_stall_needs_word, clock, reset, req_stall, rsp_valid)
   `ASSERT_IMPLIES(a_status_no_timing, clock, reset, rsp_valid && (rsp_result_kind == KIND_STATUS), (rsp_pixel_clock == 16'd0) && (rsp_h_active == 12'd0) && (rsp_refresh_rate == 7'd0))
   `ASSERT_IMPLIES(a_std_fields, clock, reset, rsp_valid && (rsp_result_kind == KIND_STANDARD), (rsp_pixel_clock == 16'd0) && (rsp_refresh_rate >= REFRESH_BIAS) && (rsp_flags == 3'd0))
   `ASSERT_IMPLIES(a_detailed_order, clock, reset, rsp_valid && (rsp_result_kind == KIND_DETAILED), (rsp_pixel_clock != 16'd0) && (rsp_h_sync_end >= rsp_h_sync_start) && (rsp_v_sync_end >= rsp_v_sync_start))
   `ASSERT_NEXT(a_stalled_word_stays, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_h_active) && $stable(rsp_flags))

endmodule
